// File: design/audio_rms_level_to_color_assert.svh
// Assertion macros used by the level meter RTL.
`ifndef AUDIO_RMS_LEVEL_TO_COLOR_ASSERT_SVH
`define AUDIO_RMS_LEVEL_TO_COLOR_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define ARLC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define ARLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/arlc_pkg.sv
// Package with constants, types and width helpers of the level meter.
package arlc_pkg;

   // Defaults of the top-level parameters
   localparam int MAX_BLOCK_DEF   = 512;
   localparam int SAMPLE_BITS_DEF = 16;

   // Field widths
   localparam int LEVEL_W    = 16;
   localparam int DRIVE_W    = 8;
   localparam int USED_W     = 10;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;
   localparam int RSP_DATA_W = 56;
   localparam int PROD_W     = 32;
   localparam int ACC_W      = 31;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_SENSITIVITY = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BRIGHTNESS  = 1'b1;

   // Item kinds
   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // Fixed-point constants
   localparam logic [15:0] SENS_RESET   = 16'd8192;
   localparam logic [15:0] BRIGHT_RESET = 16'd16384;
   localparam logic [15:0] Q14_ONE      = 16'd16384;
   localparam logic [15:0] Q14_TWO      = 16'd32768;
   localparam logic [15:0] SENS_MAX     = 16'd32768;
   localparam logic [15:0] DECAY_NOSRC  = 16'd64225;
   localparam logic [15:0] DECAY_EMPTY  = 16'd62259;
   localparam logic [ACC_W-1:0] ACC_ONE = 31'h4000_0000;

   // Color coefficients in Q0.16: red, green, blue
   localparam logic [15:0] KB_TABLE [3] = '{16'd9830, 16'd6554, 16'd5243};
   localparam logic [15:0] KL_TABLE [3] = '{16'd55706, 16'd29491, 16'd22938};

   // Width of the square accumulator
   function automatic int sum_width(input int sample_bits, input int max_block);
      return 2 * sample_bits - 1 + $clog2(max_block + 1);
   endfunction

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_DIVIDE,
      ST_ROOT,
      ST_SCALE,
      ST_SMOOTH,
      ST_DECAY,
      ST_MIX_MUL,
      ST_MIX_SUM,
      ST_OUTPUT
   } arlc_state_type;

   typedef struct packed {
      logic sample_take;
      logic tick_take;
      logic square;
      logic accum;
      logic div_step;
      logic root_step;
      logic scale;
      logic smooth;
      logic decay;
      logic mix_mul;
      logic mix_sum;
      logic out_load;
   } arlc_cmd_type;

   typedef struct packed {
      logic count_full;
      logic count_zero;
      logic rsp_busy;
   } arlc_stat_type;

endpackage

// File: design/audio_rms_level_to_color.sv
// Top level of the RMS level meter that drives an RGB color.
//
// Audio samples and frame ticks arrive on the req stream; each tick yields one rsp beat
// with the smoothed level, the red, green and blue drives and the frame's sample count
// and drop flag. A sample passes through capture, square and accumulate, or is only
// captured and dropped when the frame is already full. A tick with no source or no
// samples goes through decay, color multiply, color sum and output; a tick with samples
// goes through divide, root, scale, smooth and the same color and output steps. The mean
// comes from a one-bit-per-cycle divider of SUM_W = 2*SAMPLE_BITS - 1 + clog2(MAX_BLOCK
// + 1) steps and the root from a two-bits-per-cycle square root, both over the same shift
// register. The next item is taken while a finished result waits in the output register.
module audio_rms_level_to_color #(
   parameter int MAX_BLOCK   = arlc_pkg::MAX_BLOCK_DEF,
   parameter int SAMPLE_BITS = arlc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // tdata: sample [SAMPLE_BITS-1:0], source_present [SAMPLE_BITS], zero pad
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] req_tdata,
   // tuser: kind (0 sample, 1 frame tick)
   input  logic                                   req_tuser,
   // tdata: level [15:0], red [23:16], green [31:24], blue [39:32],
   //        samples_used [49:40], samples_dropped [50], zero pad [55:51]
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [arlc_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  logic                                   csr_we,
   input  logic [arlc_pkg::CSR_ADDR_W-1:0]        csr_addr,
   input  logic [arlc_pkg::CSR_DATA_W-1:0]        csr_wdata
);

`include "audio_rms_level_to_color_assert.svh"

   localparam logic [arlc_pkg::USED_W-1:0] USED_AT_FULL = arlc_pkg::USED_W'(MAX_BLOCK);

   arlc_pkg::arlc_cmd_type  cmd;
   arlc_pkg::arlc_stat_type stat;

   arlc_ctrl #(
      .MAX_BLOCK   (MAX_BLOCK),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_source (req_tdata[SAMPLE_BITS]),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   arlc_datapath #(
      .MAX_BLOCK   (MAX_BLOCK),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_sample (req_tdata[SAMPLE_BITS-1:0]),
      .req_source (req_tdata[SAMPLE_BITS]),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // A tick beat starts a multi-cycle update, so the input stalls right after it
   `ARLC_ASSERT_NEXT(a_tick_stalls_input, clock, reset,
      req_tvalid && req_tready && req_tuser == arlc_pkg::KIND_TICK, !req_tready,
      "input still ready after a frame tick")

   // The reported level never exceeds 2.0
   `ARLC_ASSERT_SAME(a_level_in_range, clock, reset,
      rsp_tvalid, rsp_tdata[15:0] <= arlc_pkg::Q14_TWO,
      "level above 2.0")

   // Dropped samples mean the block was full
   `ARLC_ASSERT_SAME(a_drop_means_full, clock, reset,
      rsp_tvalid && rsp_tdata[50], rsp_tdata[49:40] == USED_AT_FULL,
      "drop flagged on a frame that was not full")

endmodule

// File: design/arlc_ctrl.sv
// Controller state machine that sequences the level meter datapath.
module arlc_ctrl #(
   parameter int MAX_BLOCK   = arlc_pkg::MAX_BLOCK_DEF,
   parameter int SAMPLE_BITS = arlc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_kind,
   input  logic                   req_source,
   output logic                   req_tready,
   input  arlc_pkg::arlc_stat_type stat,
   output arlc_pkg::arlc_cmd_type  cmd
);

   localparam int SUM_W  = arlc_pkg::sum_width(SAMPLE_BITS, MAX_BLOCK);
   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
   localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(SAMPLE_BITS - 1);

   arlc_pkg::arlc_state_type state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;

   // State and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arlc_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         arlc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_kind == arlc_pkg::KIND_SAMPLE) begin
                  cmd.sample_take = 1'b1;
                  if (!stat.count_full) state_in = arlc_pkg::ST_SQUARE;
               end else begin
                  cmd.tick_take = 1'b1;
                  if (!req_source || stat.count_zero) begin
                     state_in = arlc_pkg::ST_DECAY;
                  end else begin
                     state_in = arlc_pkg::ST_DIVIDE;
                     step_in  = DIV_LAST;
                  end
               end
            end
         end
         arlc_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = arlc_pkg::ST_ACCUM;
         end
         arlc_pkg::ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = arlc_pkg::ST_IDLE;
         end
         arlc_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (step_ff == '0) begin
               state_in = arlc_pkg::ST_ROOT;
               step_in  = ROOT_LAST;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         arlc_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == '0) begin
               state_in = arlc_pkg::ST_SCALE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         arlc_pkg::ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = arlc_pkg::ST_SMOOTH;
         end
         arlc_pkg::ST_SMOOTH: begin
            cmd.smooth = 1'b1;
            state_in   = arlc_pkg::ST_MIX_MUL;
         end
         arlc_pkg::ST_DECAY: begin
            cmd.decay = 1'b1;
            state_in  = arlc_pkg::ST_MIX_MUL;
         end
         arlc_pkg::ST_MIX_MUL: begin
            cmd.mix_mul = 1'b1;
            state_in    = arlc_pkg::ST_MIX_SUM;
         end
         arlc_pkg::ST_MIX_SUM: begin
            cmd.mix_sum = 1'b1;
            state_in    = arlc_pkg::ST_OUTPUT;
         end
         arlc_pkg::ST_OUTPUT: begin
            // wait for the output register to free up
            if (!stat.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = arlc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = arlc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: design/arlc_datapath.sv
// Datapath: square accumulator, bit-serial divider and root, level and color math.
module arlc_datapath #(
   parameter int MAX_BLOCK   = arlc_pkg::MAX_BLOCK_DEF,
   parameter int SAMPLE_BITS = arlc_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  arlc_pkg::arlc_cmd_type              cmd,
   output arlc_pkg::arlc_stat_type             stat,
   input  logic                                csr_we,
   input  logic [arlc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [arlc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   input  logic                                req_source,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [arlc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   localparam int CNT_W   = $clog2(MAX_BLOCK + 1);
   localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
   localparam int SUM_W   = arlc_pkg::sum_width(SAMPLE_BITS, MAX_BLOCK);
   localparam int ROOT_W  = SAMPLE_BITS;
   localparam int SREM_W  = SAMPLE_BITS + 1;
   localparam int SH_W    = SAMPLE_BITS + 3;
   localparam int SCALE_W = SAMPLE_BITS + 16;
   localparam int LEVEL_W = arlc_pkg::LEVEL_W;
   localparam int USED_W  = arlc_pkg::USED_W;
   localparam int ACC_W   = arlc_pkg::ACC_W;
   localparam int MIX_W   = ACC_W + 8;
   localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_BLOCK);

   // Configuration registers
   logic [15:0] sens_ff, bright_ff;

   // Accumulation
   logic [SAMPLE_BITS-1:0] samp_ff;
   logic [SQ_W-1:0]        sq_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   drop_ff;

   // Per-tick working registers
   logic                   src_ff;
   logic [CNT_W-1:0]       used_ff;
   logic                   dropped_ff;
   logic [CNT_W-1:0]       den_ff;
   logic [SUM_W-1:0]       dq_ff;
   logic [CNT_W-1:0]       drem_ff;
   logic [ROOT_W-1:0]      root_ff;
   logic [SREM_W-1:0]      srem_ff;
   logic [SCALE_W-1:0]     prod_ff;
   logic [LEVEL_W-1:0]     lvl_ff;
   logic [arlc_pkg::PROD_W-1:0] pb_ff [3];
   logic [arlc_pkg::PROD_W-1:0] pl_ff [3];
   logic [ACC_W-1:0]       acc_ff [3];

   // Output register
   logic                            rsp_valid_ff;
   logic [arlc_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // Combinational terms
   logic [SAMPLE_BITS-1:0]   mag;
   logic [2*SAMPLE_BITS-1:0] sq_full;
   logic [CNT_W:0]           div_trial;
   logic                     div_ge;
   logic [CNT_W:0]           div_diff;
   logic [SH_W-1:0]          root_rem;
   logic [SH_W-1:0]          root_trial;
   logic                     root_ge;
   logic [SH_W-1:0]          root_diff;
   logic [15:0]              sens_c;
   logic [15:0]              bright_c;
   logic [LEVEL_W-1:0]       lvl_one;
   logic [SCALE_W-1:0]       tgt_wide;
   logic [LEVEL_W-1:0]       target;
   logic [LEVEL_W+2:0]       smooth_sum;
   logic [LEVEL_W-1:0]       smooth_lvl;
   logic [15:0]              decay_k;
   logic [31:0]              decay_prod;
   logic [ACC_W+1:0]         mix_add [3];
   logic [MIX_W-1:0]         mix_scaled [3];
   logic [arlc_pkg::DRIVE_W-1:0] drive [3];
   logic [CNT_W+USED_W-1:0]  used_wide;

   // Square of the sample magnitude
   assign mag     = samp_ff[SAMPLE_BITS-1] ? (~samp_ff + 1'b1) : samp_ff;
   assign sq_full = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);

   // Restoring divide step: one quotient bit shifts into dq
   assign div_trial = {drem_ff, dq_ff[SUM_W-1]};
   assign div_ge    = div_trial >= {1'b0, den_ff};
   assign div_diff  = div_trial - {1'b0, den_ff};

   // Root step: two bits of the mean enter the remainder
   assign root_rem   = {srem_ff, dq_ff[2*SAMPLE_BITS-1 -: 2]};
   assign root_trial = SH_W'({root_ff, 2'b01});
   assign root_ge    = root_rem >= root_trial;
   assign root_diff  = root_rem - root_trial;

   // Clamp registers and level
   assign sens_c   = (sens_ff > arlc_pkg::SENS_MAX) ? arlc_pkg::SENS_MAX : sens_ff;
   assign bright_c = (bright_ff > arlc_pkg::Q14_TWO) ? arlc_pkg::Q14_TWO : bright_ff;
   assign lvl_one  = (lvl_ff > arlc_pkg::Q14_ONE) ? arlc_pkg::Q14_ONE : lvl_ff;

   // Target level and smoothing toward it
   assign tgt_wide   = prod_ff >> (SAMPLE_BITS - 2);
   assign target     = (tgt_wide > SCALE_W'(arlc_pkg::Q14_TWO)) ? arlc_pkg::Q14_TWO
                                                                 : tgt_wide[LEVEL_W-1:0];
   assign smooth_sum = ((LEVEL_W+3)'(lvl_ff) * (LEVEL_W+3)'(3) + (LEVEL_W+3)'(target)
                        + (LEVEL_W+3)'(2)) >> 2;
   assign smooth_lvl = (smooth_sum > (LEVEL_W+3)'(arlc_pkg::Q14_TWO)) ? arlc_pkg::Q14_TWO
                                                                      : smooth_sum[LEVEL_W-1:0];

   // Decay factor picks on source presence
   assign decay_k    = src_ff ? arlc_pkg::DECAY_EMPTY : arlc_pkg::DECAY_NOSRC;
   assign decay_prod = 32'(lvl_ff) * 32'(decay_k);

   // Color sums and final scale to 0..255
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mix_add[c]    = (ACC_W+2)'(pb_ff[c]) + (ACC_W+2)'(pl_ff[c]);
         mix_scaled[c] = {acc_ff[c], 8'b0} - MIX_W'(acc_ff[c]) + (MIX_W'(1) << 29);
         drive[c]      = mix_scaled[c][37:30];
      end
   end

   assign used_wide = {{USED_W{1'b0}}, used_ff};

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff   <= arlc_pkg::SENS_RESET;
         bright_ff <= arlc_pkg::BRIGHT_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            arlc_pkg::CSR_SENSITIVITY: sens_ff   <= csr_wdata;
            arlc_pkg::CSR_BRIGHTNESS:  bright_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Accumulator state: count, sum and drop flag
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else if (cmd.tick_take) begin
         sum_ff   <= '0;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else if (cmd.sample_take && count_ff == COUNT_MAX) begin
         drop_ff <= 1'b1;
      end else if (cmd.accum) begin
         sum_ff   <= sum_ff + SUM_W'(sq_ff);
         count_ff <= count_ff + 1'b1;
      end
   end

   // Sample capture and square
   always_ff @(posedge clock) begin
      if (cmd.sample_take) samp_ff <= req_sample;
      if (cmd.square)      sq_ff   <= sq_full[SQ_W-1:0];
   end

   // Tick working registers
   always_ff @(posedge clock) begin
      if (cmd.tick_take) begin
         src_ff     <= req_source;
         used_ff    <= req_source ? count_ff : '0;
         dropped_ff <= req_source & drop_ff;
         den_ff     <= count_ff;
         dq_ff      <= sum_ff;
         drem_ff    <= '0;
         root_ff    <= '0;
         srem_ff    <= '0;
      end else if (cmd.div_step) begin
         drem_ff <= div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
         dq_ff   <= {dq_ff[SUM_W-2:0], div_ge};
      end else if (cmd.root_step) begin
         srem_ff <= root_ge ? root_diff[SREM_W-1:0] : root_rem[SREM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], root_ge};
         dq_ff   <= dq_ff << 2;
      end
      if (cmd.scale) prod_ff <= SCALE_W'(root_ff) * SCALE_W'(sens_c);
   end

   // Smoothed level
   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff <= '0;
      end else if (cmd.smooth) begin
         lvl_ff <= smooth_lvl;
      end else if (cmd.decay) begin
         lvl_ff <= decay_prod[31:16];
      end
   end

   // Color products and saturated sums
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (cmd.mix_mul) begin
            pb_ff[c] <= 32'(bright_c) * 32'(arlc_pkg::KB_TABLE[c]);
            pl_ff[c] <= 32'(lvl_one) * 32'(arlc_pkg::KL_TABLE[c]);
         end
         if (cmd.mix_sum) begin
            acc_ff[c] <= (mix_add[c] > (ACC_W+2)'(arlc_pkg::ACC_ONE)) ? arlc_pkg::ACC_ONE
                                                                       : mix_add[c][ACC_W-1:0];
         end
      end
   end

   // Output register: load a result beat, drop valid once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {5'b0, dropped_ff, used_wide[USED_W-1:0],
                         drive[2], drive[1], drive[0], lvl_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign stat.count_full = (count_ff == COUNT_MAX);
   assign stat.count_zero = (count_ff == '0);
   assign stat.rsp_busy   = rsp_valid_ff & ~rsp_tready;

endmodule
